### rtl/fwra_pkg.sv
// ----------------------------------------------------------------------------
// fwra_pkg: shared constants and types for the queue with running average
// Sizes of the ring store, the running sum and the fixed-point mean, the
// command codes, the sequencer states and the control bundle.
// ----------------------------------------------------------------------------
package fwra_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int VALUE_BITS    = 16;
   localparam int FRAC_BITS     = 8;
   localparam int PTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS      = VALUE_BITS + PTR_BITS;
   localparam int MEAN_BITS     = VALUE_BITS + FRAC_BITS;
   localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
   localparam int STEP_BITS     = $clog2(MEAN_BITS);

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_DIV_START,
      ST_DIV_WAIT
   } state_type;

   typedef struct packed {
      logic apply;
      logic div_start;
      logic rsp_load;
   } ctrl_type;

endpackage

### rtl/fifo_with_running_average.sv
// ----------------------------------------------------------------------------
// fifo_with_running_average: queue of unsigned values with count, sum, mean
// Sixteen-entry first-in first-out queue that also reports the mean of the
// entries it holds.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfer happens on a rising edge with start high and busy low.
//   req_cmd selects push of req_push_value or pop of the oldest entry.
//   busy rises right after the transfer and stays high until the result.
//   The sequencer applies the push or pop to the ring store, then loads the
//   divider; the restoring divider works out the mean one quotient bit at a
//   time, its done flag is registered and the result registers load on it.
//   rsp_strobe marks the result for exactly one cycle; busy falls in that
//   same cycle, so a new command can be taken while the result is shown.
//   A pop on an empty queue reports underflow, a push on a full one reports
//   overflow and drops the value; the state is then left as it was.
//   Reset empties the queue; the result has no back pressure and must be
//   taken in the cycle that it is strobed.
// ----------------------------------------------------------------------------
module fifo_with_running_average (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_push_value,
   output logic        rsp_strobe,
   output logic [15:0] rsp_popped_value,
   output logic        rsp_underflow,
   output logic        rsp_overflow,
   output logic [4:0]  rsp_entry_count,
   output logic [19:0] rsp_entry_sum,
   output logic [23:0] rsp_mean_fixed
);

   fwra_pkg::ctrl_type                  ctrl;
   logic                                div_done;
   logic [fwra_pkg::MEAN_BITS-1:0]      quotient;
   logic [fwra_pkg::COUNT_BITS-1:0]     held_count;
   logic [fwra_pkg::SUM_BITS-1:0]       running_sum;
   logic [fwra_pkg::VALUE_BITS-1:0]     popped_value;
   logic                                underflow;
   logic                                overflow;
   logic                                accept;

   logic                                cmd_ff;
   logic [fwra_pkg::VALUE_BITS-1:0]     value_ff;
   logic                                strobe_ff;
   logic [15:0]                         popped_ff;
   logic                                under_ff;
   logic                                over_ff;
   logic [4:0]                          count_ff;
   logic [19:0]                         sum_ff;
   logic [23:0]                         mean_ff;
   logic [23:0]                         mean_in;

   assign accept = start && !busy;

   fwra_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .div_done (div_done),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   fwra_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .apply        (ctrl.apply),
      .cmd          (cmd_ff),
      .push_value   (value_ff),
      .held_count   (held_count),
      .running_sum  (running_sum),
      .popped_value (popped_value),
      .underflow    (underflow),
      .overflow     (overflow)
   );

   fwra_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend ({running_sum, fwra_pkg::FRAC_BITS'(0)}),
      .divisor  (held_count),
      .done     (div_done),
      .quotient (quotient)
   );

   // An empty queue divides by zero; its mean is reported as zero instead.
   assign mean_in = (held_count == '0) ? '0 : 24'(quotient);

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         value_ff <= fwra_pkg::VALUE_BITS'(req_push_value);
      end
      if (ctrl.rsp_load) begin
         popped_ff <= 16'(popped_value);
         under_ff  <= underflow;
         over_ff   <= overflow;
         count_ff  <= 5'(held_count);
         sum_ff    <= 20'(running_sum);
         mean_ff   <= mean_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctrl.rsp_load;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_underflow    = under_ff;
   assign rsp_overflow     = over_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_entry_sum    = sum_ff;
   assign rsp_mean_fixed   = mean_ff;

endmodule

### rtl/fwra_divider.sv
// ----------------------------------------------------------------------------
// fwra_divider: restoring divider for the mean
// Produces one quotient bit per cycle; done pulses alongside the final quotient.
// ----------------------------------------------------------------------------
module fwra_divider (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [fwra_pkg::DIVIDEND_BITS-1:0]     dividend,
   input  logic [fwra_pkg::COUNT_BITS-1:0]        divisor,
   output logic                                   done,
   output logic [fwra_pkg::MEAN_BITS-1:0]         quotient
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [fwra_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic [fwra_pkg::COUNT_BITS-1:0]     rem_ff, rem_in;
   logic [fwra_pkg::MEAN_BITS-1:0]      quo_ff, quo_in;
   logic [fwra_pkg::COUNT_BITS:0]       trial;
   logic [fwra_pkg::COUNT_BITS:0]       diff;

   // For a nonzero divisor the quotient fits MEAN_BITS, so the bits above it
   // start as the remainder and are already below the divisor.
   always_comb begin
      trial   = {rem_ff, quo_ff[fwra_pkg::MEAN_BITS-1]};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = fwra_pkg::COUNT_BITS'(dividend[fwra_pkg::DIVIDEND_BITS-1:fwra_pkg::MEAN_BITS]);
         quo_in  = dividend[fwra_pkg::MEAN_BITS-1:0];
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[fwra_pkg::COUNT_BITS-1:0];
            quo_in = {quo_ff[fwra_pkg::MEAN_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[fwra_pkg::COUNT_BITS-1:0];
            quo_in = {quo_ff[fwra_pkg::MEAN_BITS-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == fwra_pkg::STEP_BITS'(fwra_pkg::MEAN_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/fwra_queue.sv
// ----------------------------------------------------------------------------
// fwra_queue: ring store with pointers, entry count and running sum
// Applies one push or pop when told to and records the flags and the
// popped value of that operation.
// ----------------------------------------------------------------------------
module fwra_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                apply,
   input  logic                                cmd,
   input  logic [fwra_pkg::VALUE_BITS-1:0]     push_value,
   output logic [fwra_pkg::COUNT_BITS-1:0]     held_count,
   output logic [fwra_pkg::SUM_BITS-1:0]       running_sum,
   output logic [fwra_pkg::VALUE_BITS-1:0]     popped_value,
   output logic                                underflow,
   output logic                                overflow
);

   logic [fwra_pkg::VALUE_BITS-1:0] store [fwra_pkg::QUEUE_DEPTH];
   logic [fwra_pkg::VALUE_BITS-1:0] rd_data_ff;

   logic [fwra_pkg::PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [fwra_pkg::PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [fwra_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [fwra_pkg::SUM_BITS-1:0]   sum_ff, sum_in;
   logic [fwra_pkg::VALUE_BITS-1:0] popped_ff, popped_in;
   logic                            under_ff, under_in;
   logic                            over_ff, over_in;
   logic                            do_write;
   logic                            is_full;
   logic                            is_empty;

   function automatic logic [fwra_pkg::PTR_BITS-1:0] ring_next(
      input logic [fwra_pkg::PTR_BITS-1:0] ptr
   );
      if (ptr == fwra_pkg::PTR_BITS'(fwra_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign is_full  = (count_ff == fwra_pkg::COUNT_BITS'(fwra_pkg::QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      popped_in = popped_ff;
      under_in  = under_ff;
      over_in   = over_ff;
      do_write  = 1'b0;
      if (apply) begin
         popped_in = '0;
         under_in  = 1'b0;
         over_in   = 1'b0;
         if (cmd == fwra_pkg::CMD_PUSH) begin
            if (is_full) begin
               over_in = 1'b1;
            end else begin
               do_write  = 1'b1;
               wr_ptr_in = ring_next(wr_ptr_ff);
               count_in  = count_ff + 1'b1;
               sum_in    = sum_ff + fwra_pkg::SUM_BITS'(push_value);
            end
         end else begin
            if (is_empty) begin
               under_in = 1'b1;
            end else begin
               // The read port has followed the read pointer since the last pop.
               popped_in = rd_data_ff;
               rd_ptr_in = ring_next(rd_ptr_ff);
               count_in  = count_ff - 1'b1;
               sum_in    = sum_ff - fwra_pkg::SUM_BITS'(rd_data_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         store[wr_ptr_ff] <= push_value;
      end
      rd_data_ff <= store[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
      end
      popped_ff <= popped_in;
      under_ff  <= under_in;
      over_ff   <= over_in;
   end

   assign held_count   = count_ff;
   assign running_sum  = sum_ff;
   assign popped_value = popped_ff;
   assign underflow    = under_ff;
   assign overflow     = over_ff;

endmodule

### rtl/fwra_ctrl.sv
// ----------------------------------------------------------------------------
// fwra_ctrl: operation sequencer
// Steps each command through the queue update and the mean division.
// ----------------------------------------------------------------------------
module fwra_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                div_done,
   output logic                busy,
   output fwra_pkg::ctrl_type  ctrl
);

   fwra_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fwra_pkg::ST_IDLE: begin
            if (start) begin
               state_in = fwra_pkg::ST_APPLY;
            end
         end
         fwra_pkg::ST_APPLY:     state_in = fwra_pkg::ST_DIV_START;
         fwra_pkg::ST_DIV_START: state_in = fwra_pkg::ST_DIV_WAIT;
         fwra_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = fwra_pkg::ST_IDLE;
            end
         end
         default: state_in = fwra_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      unique case (state_ff)
         fwra_pkg::ST_IDLE:      busy = 1'b0;
         fwra_pkg::ST_APPLY:     ctrl.apply = 1'b1;
         fwra_pkg::ST_DIV_START: ctrl.div_start = 1'b1;
         fwra_pkg::ST_DIV_WAIT:  ctrl.rsp_load = div_done;
         default:                busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fwra_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### tb/sv/tb_fifo_with_running_average.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_with_running_average: self-checking bench for the averaging queue
// Drives push and pop commands through the start/busy handshake. A local
// queue model predicts every result, and each strobed result is compared
// field by field. The run covers empty and full queues, pointer wrap and the
// fractional mean, then long random traffic with idle bursts.
// ----------------------------------------------------------------------------
module tb_fifo_with_running_average;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 1080;
   localparam int QUIET_TAIL   = 150;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [fwra_pkg::VALUE_BITS-1:0] popped_value;
      logic                            underflow;
      logic                            overflow;
      logic [fwra_pkg::COUNT_BITS-1:0] entry_count;
      logic [fwra_pkg::SUM_BITS-1:0]   entry_sum;
      logic [fwra_pkg::MEAN_BITS-1:0]  mean_fixed;
   } queue_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_cmd = fwra_pkg::CMD_PUSH;
   logic [15:0] req_push_value = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_popped_value;
   logic        rsp_underflow;
   logic        rsp_overflow;
   logic [4:0]  rsp_entry_count;
   logic [19:0] rsp_entry_sum;
   logic [23:0] rsp_mean_fixed;

   // Local copy of the queue state.
   logic [fwra_pkg::VALUE_BITS-1:0] model_ring [fwra_pkg::QUEUE_DEPTH];
   logic [fwra_pkg::PTR_BITS-1:0]   model_head = '0;
   logic [fwra_pkg::PTR_BITS-1:0]   model_tail = '0;
   logic [fwra_pkg::COUNT_BITS-1:0] model_count = '0;
   logic [fwra_pkg::SUM_BITS-1:0]   model_sum = '0;

   queue_report_type awaited_reports [$];
   queue_report_type due_report;
   int               error_count = 0;
   int               cycle_count = 0;

   always #1 clock = ~clock;

   fifo_with_running_average u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_push_value   (req_push_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_popped_value (rsp_popped_value),
      .rsp_underflow    (rsp_underflow),
      .rsp_overflow     (rsp_overflow),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_entry_sum    (rsp_entry_sum),
      .rsp_mean_fixed   (rsp_mean_fixed)
   );

   // Applies one command to the local queue and records the report it yields.
   task automatic model_queue_command(
      input logic                            cmd,
      input logic [fwra_pkg::VALUE_BITS-1:0] value
   );
      queue_report_type                   report;
      logic [fwra_pkg::DIVIDEND_BITS-1:0] dividend;
      report = '0;
      if (cmd == fwra_pkg::CMD_PUSH) begin
         if (model_count == fwra_pkg::QUEUE_DEPTH) begin
            report.overflow = 1'b1;
         end else begin
            model_ring[model_tail] = value;
            model_tail  = (model_tail == fwra_pkg::QUEUE_DEPTH - 1) ? '0 : model_tail + 1'b1;
            model_count = model_count + 1'b1;
            model_sum   = model_sum + value;
         end
      end else begin
         if (model_count == 0) begin
            report.underflow = 1'b1;
         end else begin
            report.popped_value = model_ring[model_head];
            model_head  = (model_head == fwra_pkg::QUEUE_DEPTH - 1) ? '0 : model_head + 1'b1;
            model_count = model_count - 1'b1;
            model_sum   = model_sum - report.popped_value;
         end
      end
      report.entry_count = model_count;
      report.entry_sum   = model_sum;
      if (model_count != 0) begin
         dividend          = {model_sum, {fwra_pkg::FRAC_BITS{1'b0}}};
         report.mean_fixed = fwra_pkg::MEAN_BITS'(dividend / model_count);
      end
      awaited_reports.push_back(report);
   endtask

   // Called just after a falling edge; returns just after the next falling edge
   // following the transfer, with start still high.
   task automatic send_command(
      input logic                            cmd,
      input logic [fwra_pkg::VALUE_BITS-1:0] value
   );
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_push_value <= value;
      do @(posedge clock); while (busy);
      model_queue_command(cmd, value);
      @(negedge clock);
   endtask

   // An idle burst with start low, optionally placed after busy has fallen
   // so that the gap lands on the ready phase rather than inside the division.
   task automatic idle_sender(input bit after_busy);
      int unsigned burst;
      burst = $urandom_range(1, 13);
      start <= 1'b0;
      if (after_busy) begin
         do @(posedge clock); while (busy);
      end
      repeat (burst) @(negedge clock);
   endtask

   task automatic wait_for_all_reports();
      start <= 1'b0;
      do @(negedge clock); while (awaited_reports.size() != 0);
   endtask

   task automatic test_underflow_on_empty();
      send_command(fwra_pkg::CMD_POP, 16'hFFFF);
   endtask

   // Entries 0 and 1 give a mean of one half, which exercises the fraction bits.
   task automatic test_mean_fraction();
      send_command(fwra_pkg::CMD_PUSH, 16'h0000);
      send_command(fwra_pkg::CMD_PUSH, 16'h0001);
      send_command(fwra_pkg::CMD_POP, 16'h0000);
      send_command(fwra_pkg::CMD_POP, 16'hFFFF);
   endtask

   // Filling with the largest value gives the largest sum; the fill itself
   // carries the write pointer past the end of the store.
   task automatic test_full_queue_and_wrap();
      int i;
      for (i = 0; i < fwra_pkg::QUEUE_DEPTH; i++) begin
         send_command(fwra_pkg::CMD_PUSH, 16'hFFFF);
      end
      send_command(fwra_pkg::CMD_PUSH, 16'h0000);
      send_command(fwra_pkg::CMD_POP, 16'h0000);
      send_command(fwra_pkg::CMD_PUSH, 16'h1234);
      wait_for_all_reports();
   endtask

   // Runs of push-heavy, balanced and pop-heavy traffic so that the queue
   // swings between full and empty many times.
   task automatic test_random_traffic(input int unsigned item_total);
      int unsigned                     n;
      int unsigned                     run_left;
      int unsigned                     push_odds;
      bit                              quiet_run;
      bit                              idling_allowed;
      logic                            cmd;
      logic [fwra_pkg::VALUE_BITS-1:0] value;
      run_left  = 0;
      push_odds = 50;
      quiet_run = 1'b0;
      for (n = 0; n < item_total; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
               0: push_odds = 80;
               1: push_odds = 50;
               default: push_odds = 20;
            endcase
            quiet_run = ($urandom_range(0, 3) == 0);
         end
         run_left--;
         cmd = ($urandom_range(1, 100) <= push_odds) ? fwra_pkg::CMD_PUSH : fwra_pkg::CMD_POP;
         case ($urandom_range(0, 5))
            0: value = '0;
            1: value = '1;
            default: value = fwra_pkg::VALUE_BITS'($urandom);
         endcase
         send_command(cmd, value);
         idling_allowed = !quiet_run && (n + QUIET_TAIL < item_total);
         if (idling_allowed) begin
            case ($urandom_range(0, 7))
               0: idle_sender(1'b0);
               1: idle_sender(1'b1);
               2: if ($urandom_range(0, 39) == 0) wait_for_all_reports();
               default: ;
            endcase
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_reports.size() == 0) begin
            $error("result strobed with no transfer awaiting it");
            error_count++;
         end else begin
            due_report = awaited_reports.pop_front();
            if (rsp_popped_value !== due_report.popped_value) begin
               $error("rsp_popped_value: expected %0d, actual %0d",
                      due_report.popped_value, rsp_popped_value);
               error_count++;
            end
            if (rsp_underflow !== due_report.underflow) begin
               $error("rsp_underflow: expected %0d, actual %0d",
                      due_report.underflow, rsp_underflow);
               error_count++;
            end
            if (rsp_overflow !== due_report.overflow) begin
               $error("rsp_overflow: expected %0d, actual %0d",
                      due_report.overflow, rsp_overflow);
               error_count++;
            end
            if (rsp_entry_count !== due_report.entry_count) begin
               $error("rsp_entry_count: expected %0d, actual %0d",
                      due_report.entry_count, rsp_entry_count);
               error_count++;
            end
            if (rsp_entry_sum !== due_report.entry_sum) begin
               $error("rsp_entry_sum: expected %0d, actual %0d",
                      due_report.entry_sum, rsp_entry_sum);
               error_count++;
            end
            if (rsp_mean_fixed !== due_report.mean_fixed) begin
               $error("rsp_mean_fixed: expected %0d, actual %0d",
                      due_report.mean_fixed, rsp_mean_fixed);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_fifo_with_running_average: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_underflow_on_empty();
      test_mean_fraction();
      test_full_queue_and_wrap();
      test_random_traffic(RANDOM_ITEMS);
      wait_for_all_reports();
      // Any result strobed after this point has no transfer behind it.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_reports.size() == 0) begin
         $display("tb_fifo_with_running_average: PASS");
      end else begin
         $display("tb_fifo_with_running_average: FAIL");
      end
      $finish;
   end

endmodule

### fifo_with_running_average.f
rtl/fwra_pkg.sv
rtl/fwra_divider.sv
rtl/fwra_queue.sv
rtl/fwra_ctrl.sv
rtl/fifo_with_running_average.sv
tb/sv/tb_fifo_with_running_average.sv
